// File: sv/html_to_text_byte_filter_assert.svh
// ----------------------------------------------------------------------------
// html_to_text_byte_filter assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ----------------------------------------------------------------------------
`ifndef HTML_TO_TEXT_BYTE_FILTER_ASSERT_SVH
`define HTML_TO_TEXT_BYTE_FILTER_ASSERT_SVH

// same-cycle implication
`define HTT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HTT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/htt_pkg.sv
// ----------------------------------------------------------------------------
// htt_pkg
// Payload types, controller/datapath interface types and default sizes for
// the markup-to-text byte filter.
// ----------------------------------------------------------------------------
package htt_pkg;

    localparam int TAG_MAX_DEF    = 15;
    localparam int ENTITY_MAX_DEF = 9;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       doc_start;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic flush_emit;
        logic tail_emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic start_flush;
        logic start_tail;
        logic flush_last;
        logic tail_pending;
    } t_dp_status;

endpackage

// File: sv/htt_ctrl.sv
// ----------------------------------------------------------------------------
// htt_ctrl
// Sequencer: accepts one input transaction, then steps the datapath through
// the entity flush bytes and the trailing text byte when a run has several.
// ----------------------------------------------------------------------------
`include "html_to_text_byte_filter_assert.svh"

module htt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  htt_pkg::t_dp_status i_status,
    output htt_pkg::t_dp_cmd    o_cmd,
    output logic                o_in_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLUSH,
        S_TAIL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic [2:0] cmd_vec;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid && i_status.out_free;
                if (o_cmd.accept) begin
                    if (i_status.start_flush) begin
                        n_state = S_FLUSH;
                    end else if (i_status.start_tail) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_FLUSH: begin
                o_cmd.flush_emit = i_status.out_free;
                if (i_status.out_free && i_status.flush_last) begin
                    n_state = i_status.tail_pending ? S_TAIL : S_IDLE;
                end
            end
            S_TAIL: begin
                o_cmd.tail_emit = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = !((r_state == S_IDLE) && i_status.out_free);
    assign cmd_vec    = {o_cmd.accept, o_cmd.flush_emit, o_cmd.tail_emit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `HTT_ASSERT_IMP(a_cmd_onehot, 1'b1, $onehot0(cmd_vec), "more than one datapath command")
    `HTT_ASSERT_IMP(a_tail_known, r_state == S_TAIL, i_status.tail_pending,
                    "tail state without a pending tail byte")

endmodule

// File: sv/htt_dp.sv
// ----------------------------------------------------------------------------
// htt_dp
// Filter datapath: tag, entity and whitespace state, tag and entity letter
// buffers, incremental numeric entity value, flush counter and output register.
// ----------------------------------------------------------------------------
`include "html_to_text_byte_filter_assert.svh"

module htt_dp #(
    parameter int TAG_MAX    = htt_pkg::TAG_MAX_DEF,
    parameter int ENTITY_MAX = htt_pkg::ENTITY_MAX_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  htt_pkg::t_in_item   i_in_item,
    input  logic                i_out_stall,
    input  htt_pkg::t_dp_cmd    i_cmd,
    output htt_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output htt_pkg::t_out_item  o_out_item
);

    localparam int TIW = (TAG_MAX > 1) ? $clog2(TAG_MAX) : 1;
    localparam int TCW = $clog2(TAG_MAX + 1);
    localparam int EIW = (ENTITY_MAX > 1) ? $clog2(ENTITY_MAX) : 1;
    localparam int ECW = $clog2(ENTITY_MAX + 1);

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;

    function automatic logic [8:0] text_out(input logic [7:0] c, input logic [7:0] prev);
        logic [8:0] res;
        res = {1'b1, c};
        if (c == CH_CR || c == CH_LF || c == CH_TAB || c == CH_SP) begin
            res = {(prev != CH_SP && prev != CH_LF && prev != CH_CR), CH_SP};
        end else if (c == CH_LT || c == CH_AMP) begin
            res = {1'b0, c};
        end
        return res;
    endfunction

    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
        logic [4:0] res;
        res = '0;
        if (c >= "0" && c <= "9") begin
            res = {1'b1, c[3:0]};
        end else if (hex && c >= "a" && c <= "f") begin
            res = {1'b1, 4'(c - 8'h57)};
        end else if (hex && c >= "A" && c <= "F") begin
            res = {1'b1, 4'(c - 8'h37)};
        end
        return res;
    endfunction

    // configuration and control state
    logic           r_mode;
    logic           r_in_tag, n_in_tag;
    logic           r_in_ent, n_in_ent;
    logic           r_skip, n_skip;
    logic           r_closing, n_closing;
    logic [TCW-1:0] r_tag_cnt, n_tag_cnt;
    logic [ECW-1:0] r_ent_cnt, n_ent_cnt;
    logic [7:0]     r_prev, n_prev;
    logic           r_out_valid;

    // payload state
    logic [7:0]     r_tag [TAG_MAX];
    logic [7:0]     r_ent [ENTITY_MAX];
    logic [7:0]     r_ent_last;
    logic           r_is_hash, n_is_hash;
    logic           r_hex, n_hex;
    logic           r_run, n_run;
    logic [8:0]     r_num, n_num;
    logic [ECW-1:0] r_flush_len;
    logic [EIW-1:0] r_idx;
    logic           r_tail_vld;
    logic [7:0]     r_tail_byte;
    htt_pkg::t_out_item r_out_item;

    // effective state after an optional document start
    logic           doc;
    logic [7:0]     c;
    logic           eff_in_tag, eff_in_ent, eff_skip, eff_closing;
    logic [TCW-1:0] eff_tag_cnt;
    logic [ECW-1:0] eff_ent_cnt;
    logic [7:0]     eff_prev;

    logic [47:0]    tag_head;
    logic [31:0]    ent_head;
    logic           tag_skip_name, tag_nl;
    logic           tag_char, ent_keep;
    logic [7:0]     lc;
    logic [4:0]     dig;
    logic [12:0]    scaled, sum;
    logic [8:0]     txt, tail_txt;
    logic [7:0]     flush_prev;

    logic           first_vld;
    logic [7:0]     first_byte;
    logic [ECW-1:0] flush_n;
    logic           tail_vld;
    logic [7:0]     tail_byte;
    logic           ent_wr, tag_wr;
    logic           out_free, out_load;
    htt_pkg::t_out_item out_next;

    assign c   = i_in_item.in_byte;
    assign doc = i_in_item.doc_start;

    assign eff_in_tag  = doc ? 1'b0 : r_in_tag;
    assign eff_in_ent  = doc ? 1'b0 : r_in_ent;
    assign eff_skip    = doc ? 1'b0 : r_skip;
    assign eff_closing = doc ? 1'b0 : r_closing;
    assign eff_tag_cnt = doc ? '0 : r_tag_cnt;
    assign eff_ent_cnt = doc ? '0 : r_ent_cnt;
    assign eff_prev    = doc ? 8'h00 : r_prev;

    assign tag_head = {r_tag[0], r_tag[1], r_tag[2], r_tag[3], r_tag[4], r_tag[5]};
    assign ent_head = {r_ent[0], r_ent[1], r_ent[2], r_ent[3]};

    assign tag_skip_name = (eff_tag_cnt == TCW'(6) && tag_head == "script")
                        || (eff_tag_cnt == TCW'(5) && tag_head[47:8] == "style");
    assign tag_nl = (eff_tag_cnt == TCW'(2) && tag_head[47:32] == "br")
                 || (eff_tag_cnt == TCW'(1) && tag_head[47:40] == "p")
                 || (eff_tag_cnt == TCW'(3) && tag_head[47:24] == "div")
                 || (eff_tag_cnt == TCW'(2) && tag_head[47:32] == "li")
                 || (eff_tag_cnt == TCW'(2) && tag_head[47:32] == "tr")
                 || (eff_tag_cnt == TCW'(2) && tag_head[47:40] == "h"
                     && tag_head[39:32] >= "1" && tag_head[39:32] <= "6");

    assign tag_char = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z")
                   || (c >= "0" && c <= "9") || c == CH_SLASH;
    assign lc       = (c >= "A" && c <= "Z") ? (c + 8'h20) : c;
    assign ent_keep = (eff_ent_cnt < ECW'(ENTITY_MAX)) && (c >= CH_SP) && (c != CH_LT);

    assign txt        = text_out(c, eff_prev);
    assign flush_prev = (eff_ent_cnt != '0) ? r_ent_last : CH_AMP;
    assign tail_txt   = text_out(c, flush_prev);

    always_comb begin
        n_in_tag   = eff_in_tag;
        n_in_ent   = eff_in_ent;
        n_skip     = eff_skip;
        n_closing  = eff_closing;
        n_tag_cnt  = eff_tag_cnt;
        n_ent_cnt  = eff_ent_cnt;
        first_vld  = 1'b0;
        first_byte = c;
        flush_n    = '0;
        tail_vld   = 1'b0;
        tail_byte  = tail_txt[7:0];
        ent_wr     = 1'b0;
        tag_wr     = 1'b0;
        if (!r_mode) begin
            first_vld = 1'b1;
        end else if (eff_in_ent) begin
            if (c == CH_SEMI) begin
                first_vld = 1'b1;
                n_in_ent  = 1'b0;
                n_ent_cnt = '0;
                if (eff_ent_cnt == ECW'(3) && ent_head[31:8] == "amp") begin
                    first_byte = CH_AMP;
                end else if (eff_ent_cnt == ECW'(2) && ent_head[31:16] == "lt") begin
                    first_byte = CH_LT;
                end else if (eff_ent_cnt == ECW'(2) && ent_head[31:16] == "gt") begin
                    first_byte = CH_GT;
                end else if (eff_ent_cnt == ECW'(4) && ent_head == "quot") begin
                    first_byte = CH_QUOT;
                end else if (eff_ent_cnt == ECW'(4) && ent_head == "apos") begin
                    first_byte = CH_APOS;
                end else if (eff_ent_cnt == ECW'(4) && ent_head == "nbsp") begin
                    first_byte = CH_SP;
                end else if (eff_ent_cnt != '0 && r_is_hash) begin
                    first_byte = (r_num != 9'd0 && r_num < 9'h080) ? r_num[7:0] : CH_QMARK;
                end else begin
                    first_byte = CH_AMP;
                    flush_n    = eff_ent_cnt;
                end
            end else if (ent_keep) begin
                ent_wr    = 1'b1;
                n_ent_cnt = eff_ent_cnt + ECW'(1);
            end else begin
                first_vld  = 1'b1;
                first_byte = CH_AMP;
                flush_n    = eff_ent_cnt;
                n_in_ent   = 1'b0;
                n_ent_cnt  = '0;
                if (c == CH_AMP) begin
                    n_in_ent = 1'b1;
                end else if (c == CH_LT) begin
                    n_in_tag  = 1'b1;
                    n_tag_cnt = '0;
                    n_closing = 1'b0;
                end else begin
                    tail_vld = tail_txt[8];
                end
            end
        end else if (eff_in_tag) begin
            if (c == CH_GT) begin
                if (!eff_closing && tag_skip_name) begin
                    n_skip = 1'b1;
                end else if (eff_closing && eff_skip && tag_skip_name) begin
                    n_skip = 1'b0;
                end
                if (!n_skip && tag_nl && eff_prev != CH_LF) begin
                    first_vld  = 1'b1;
                    first_byte = CH_LF;
                end
                n_in_tag  = 1'b0;
                n_tag_cnt = '0;
                n_closing = 1'b0;
            end else if (eff_tag_cnt == '0 && c == CH_SLASH) begin
                n_closing = 1'b1;
            end else if (tag_char && eff_tag_cnt < TCW'(TAG_MAX)) begin
                tag_wr    = 1'b1;
                n_tag_cnt = eff_tag_cnt + TCW'(1);
            end
        end else if (eff_skip) begin
            if (c == CH_LT) begin
                n_in_tag  = 1'b1;
                n_tag_cnt = '0;
                n_closing = 1'b0;
            end
        end else begin
            first_vld = txt[8];
            if (c == CH_LT) begin
                n_in_tag  = 1'b1;
                n_tag_cnt = '0;
                n_closing = 1'b0;
            end else if (c == CH_AMP) begin
                n_in_ent  = 1'b1;
                n_ent_cnt = '0;
            end else begin
                first_byte = txt[7:0];
            end
        end
    end

    always_comb begin
        n_prev = eff_prev;
        if (r_mode) begin
            if (tail_vld) begin
                n_prev = tail_byte;
            end else if (flush_n != '0) begin
                n_prev = r_ent_last;
            end else if (first_vld) begin
                n_prev = first_byte;
            end
        end
    end

    // numeric entity value, one digit per stored letter
    assign dig    = digit_of(c, r_hex);
    assign scaled = r_hex ? {r_num, 4'b0000}
                          : ({1'b0, r_num, 3'b000} + {3'b000, r_num, 1'b0});
    assign sum    = scaled + 13'(dig[3:0]);

    always_comb begin
        n_is_hash = r_is_hash;
        n_hex     = r_hex;
        n_run     = r_run;
        n_num     = r_num;
        if (eff_ent_cnt == '0) begin
            n_is_hash = (c == CH_HASH);
            n_hex     = 1'b0;
            n_run     = 1'b1;
            n_num     = '0;
        end else if (eff_ent_cnt == ECW'(1) && (c == "x" || c == "X")) begin
            n_hex = 1'b1;
        end else if (r_run && dig[4]) begin
            n_num = (sum > 13'd255) ? 9'h100 : sum[8:0];
        end else begin
            n_run = 1'b0;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (i_cmd.accept && first_vld) || i_cmd.flush_emit || i_cmd.tail_emit;

    always_comb begin
        out_next.out_byte    = first_byte;
        out_next.last_of_run = (flush_n == '0) && !tail_vld;
        if (i_cmd.flush_emit) begin
            out_next.out_byte    = r_ent[r_idx];
            out_next.last_of_run = o_status.flush_last && !r_tail_vld;
        end else if (i_cmd.tail_emit) begin
            out_next.out_byte    = r_tail_byte;
            out_next.last_of_run = 1'b1;
        end
    end

    assign o_status.out_free     = out_free;
    assign o_status.start_flush  = (flush_n != '0);
    assign o_status.start_tail   = tail_vld;
    assign o_status.flush_last   = (ECW'(r_idx) == r_flush_len - ECW'(1));
    assign o_status.tail_pending = r_tail_vld;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b1;
            r_in_tag    <= 1'b0;
            r_in_ent    <= 1'b0;
            r_skip      <= 1'b0;
            r_closing   <= 1'b0;
            r_tag_cnt   <= '0;
            r_ent_cnt   <= '0;
            r_prev      <= 8'h00;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (i_cmd.accept) begin
                r_in_tag  <= n_in_tag;
                r_in_ent  <= n_in_ent;
                r_skip    <= n_skip;
                r_closing <= n_closing;
                r_tag_cnt <= n_tag_cnt;
                r_ent_cnt <= n_ent_cnt;
                r_prev    <= n_prev;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_item <= out_next;
        end
        if (i_cmd.accept) begin
            r_flush_len <= flush_n;
            r_idx       <= '0;
            r_tail_vld  <= tail_vld;
            r_tail_byte <= tail_byte;
        end else if (i_cmd.flush_emit) begin
            r_idx <= r_idx + EIW'(1);
        end
        if (i_cmd.accept && ent_wr) begin
            r_ent[eff_ent_cnt[EIW-1:0]] <= c;
            r_ent_last                  <= c;
            r_is_hash                   <= n_is_hash;
            r_hex                       <= n_hex;
            r_run                       <= n_run;
            r_num                       <= n_num;
        end
        if (i_cmd.accept && tag_wr) begin
            r_tag[eff_tag_cnt[TIW-1:0]] <= lc;
        end
    end

    `HTT_ASSERT_IMP(a_load_free, out_load, out_free, "output register overwritten while held")
    `HTT_ASSERT_IMP(a_flush_range, i_cmd.flush_emit, ECW'(r_idx) < r_flush_len,
                    "flush index beyond stored entity letters")

endmodule

// File: sv/html_to_text_byte_filter.sv
// A result byte is registered in the output register when its input is accepted.
// One input per cycle when it gives at most one result byte and the output is not stalled.
// An entity flush of n stored letters emits '&', the n letters and any trailing text byte
// in turn through the single output register that all result bytes pass through.
// Reset (synchronous, active low) clears the control state and sets markup_mode to 1.
// ----------------------------------------------------------------------------
// html_to_text_byte_filter
// Markup-to-text byte filter: tags dropped, entities decoded, whitespace
// collapsed, script/style text skipped; copy mode passes bytes unchanged.
// ----------------------------------------------------------------------------
module html_to_text_byte_filter #(
    parameter int TAG_MAX    = htt_pkg::TAG_MAX_DEF,
    parameter int ENTITY_MAX = htt_pkg::ENTITY_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  htt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output htt_pkg::t_out_item o_out_item
);

    htt_pkg::t_dp_cmd    cmd;
    htt_pkg::t_dp_status status;

    htt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    htt_dp #(
        .TAG_MAX    (TAG_MAX),
        .ENTITY_MAX (ENTITY_MAX)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_item     (i_in_item),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item)
    );

endmodule

// File: tb/tb_html_to_text_byte_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_html_to_text_byte_filter
// Drives markup byte streams through the filter in both modes. Streams are
// built from text runs, whitespace, tags, entities, script/style blocks and
// raw noise. A predictor computes the expected text bytes for every accepted
// transaction, and every output transaction is checked against the oldest
// one. The sender and the receiver idle at random rates.
// ----------------------------------------------------------------------------

class text_scoreboard;
    bit                 markup_mode = 1'b1;
    bit                 in_tag;
    bit                 ent_open;
    bit                 skipping;
    bit                 closing;
    bit [7:0]           tag_buf [htt_pkg::TAG_MAX_DEF];
    bit [7:0]           ent_buf [htt_pkg::ENTITY_MAX_DEF];
    int                 tag_cnt;
    int                 ent_cnt;
    bit [7:0]           last_text;
    bit [7:0]           burst [$];
    htt_pkg::t_out_item pending [$];
    int                 n_inputs;
    int                 n_results;
    int                 n_errors;

    function void clear_state();
        in_tag    = 1'b0;
        ent_open  = 1'b0;
        skipping  = 1'b0;
        closing   = 1'b0;
        tag_cnt   = 0;
        ent_cnt   = 0;
        last_text = 8'h00;
    endfunction

    function void put(bit [7:0] b);
        if (burst.size() < htt_pkg::ENTITY_MAX_DEF + 2) burst.push_back(b);
        last_text = b;
    endfunction

    function bit tag_is(string name);
        int i;
        if (name.len() != tag_cnt) return 1'b0;
        for (i = 0; i < tag_cnt; i++) if (tag_buf[i] != name[i]) return 1'b0;
        return 1'b1;
    endfunction

    function bit ent_is(string name);
        int i;
        if (name.len() != ent_cnt) return 1'b0;
        for (i = 0; i < ent_cnt; i++) if (ent_buf[i] != name[i]) return 1'b0;
        return 1'b1;
    endfunction

    function int digit_of(bit [7:0] c, int unsigned radix);
        if (c >= "0" && c <= "9") return c - "0";
        if (radix == 16) begin
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
        end
        return -1;
    endfunction

    function void flush_entity();
        int i;
        put("&");
        for (i = 0; i < ent_cnt; i++) put(ent_buf[i]);
    endfunction

    function void decode_entity();
        int unsigned radix;
        int unsigned idx;
        int unsigned value;
        int          d;
        if (ent_is("amp")) put("&");
        else if (ent_is("lt")) put("<");
        else if (ent_is("gt")) put(">");
        else if (ent_is("quot")) put("\"");
        else if (ent_is("apos")) put("'");
        else if (ent_is("nbsp")) put(" ");
        else if (ent_cnt > 0 && ent_buf[0] == "#") begin
            radix = 10;
            idx   = 1;
            value = 0;
            if (ent_cnt > 1 && (ent_buf[1] == "x" || ent_buf[1] == "X")) begin
                radix = 16;
                idx   = 2;
            end
            for (; idx < ent_cnt; idx++) begin
                d = digit_of(ent_buf[idx], radix);
                if (d < 0) break;
                value = value * radix + d;
                if (value > 255) value = 256;
            end
            put((value > 0 && value < 128) ? value[7:0] : 8'h3F);
        end else begin
            flush_entity();
        end
    endfunction

    function void text_byte(bit [7:0] c);
        if (c == "<") begin
            in_tag  = 1'b1;
            tag_cnt = 0;
            closing = 1'b0;
        end else if (c == "&") begin
            ent_open = 1'b1;
            ent_cnt  = 0;
        end else if (c == 8'h0D || c == 8'h0A || c == 8'h09 || c == 8'h20) begin
            if (last_text != 8'h20 && last_text != 8'h0A && last_text != 8'h0D) put(8'h20);
        end else begin
            put(c);
        end
    endfunction

    function void end_tag();
        bit skip_name;
        skip_name = tag_is("script") || tag_is("style");
        if (!closing && skip_name) skipping = 1'b1;
        else if (closing && skipping && skip_name) skipping = 1'b0;
        if (!skipping && (tag_is("br") || tag_is("p") || tag_is("div") || tag_is("li") ||
                tag_is("tr") || tag_is("h1") || tag_is("h2") || tag_is("h3") ||
                tag_is("h4") || tag_is("h5") || tag_is("h6"))) begin
            if (last_text != 8'h0A) put(8'h0A);
        end
        in_tag  = 1'b0;
        tag_cnt = 0;
        closing = 1'b0;
    endfunction

    function void filter_byte(bit [7:0] c);
        if (ent_open) begin
            if (c == ";") begin
                decode_entity();
                ent_open = 1'b0;
                ent_cnt  = 0;
            end else if (ent_cnt < htt_pkg::ENTITY_MAX_DEF && c >= 8'h20 && c != "<") begin
                ent_buf[ent_cnt] = c;
                ent_cnt++;
            end else begin
                flush_entity();
                ent_open = 1'b0;
                ent_cnt  = 0;
                if (c == "&") ent_open = 1'b1;
                else text_byte(c);
            end
        end else if (in_tag) begin
            if (c == ">") begin
                end_tag();
            end else if (tag_cnt == 0 && c == "/") begin
                closing = 1'b1;
            end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                    (c >= "0" && c <= "9") || c == "/") begin
                if (tag_cnt < htt_pkg::TAG_MAX_DEF) begin
                    if (c >= "A" && c <= "Z") c = c + 8'h20;
                    tag_buf[tag_cnt] = c;
                    tag_cnt++;
                end
            end
        end else if (skipping) begin
            if (c == "<") begin
                in_tag  = 1'b1;
                tag_cnt = 0;
                closing = 1'b0;
            end
        end else begin
            text_byte(c);
        end
    endfunction

    function void note_input(htt_pkg::t_in_item item);
        htt_pkg::t_out_item r;
        int                 k;
        n_inputs++;
        burst.delete();
        if (item.doc_start) clear_state();
        if (markup_mode) filter_byte(item.in_byte);
        else burst.push_back(item.in_byte);
        for (k = 0; k < burst.size(); k++) begin
            r.out_byte    = burst[k];
            r.last_of_run = (k == burst.size() - 1);
            pending.push_back(r);
        end
    endfunction

    function void check_result(htt_pkg::t_out_item got);
        htt_pkg::t_out_item want;
        n_results++;
        if (pending.size() == 0) begin
            $error("out_byte expected none actual %02h", got.out_byte);
            n_errors++;
            return;
        end
        want = pending.pop_front();
        if (got.out_byte !== want.out_byte) begin
            $error("out_byte expected %02h actual %02h", want.out_byte, got.out_byte);
            n_errors++;
        end
        if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run expected %0b actual %0b", want.last_of_run, got.last_of_run);
            n_errors++;
        end
    endfunction
endclass

module tb_html_to_text_byte_filter;

    localparam int IDLE_LIMIT = 3000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic               i_cfg_wr_data;
    logic               i_in_valid;
    logic               o_in_stall;
    htt_pkg::t_in_item  i_in_item;
    logic               o_out_valid;
    logic               i_out_stall;
    htt_pkg::t_out_item o_out_item;

    text_scoreboard sb = new();
    int             send_idle_pct;
    int             rcv_stall_pct;
    int             idle_cycles;

    string tag_words [0:15] = '{"br", "p", "div", "li", "tr", "h1", "h2", "h3", "h4", "h5",
                                "h6", "script", "style", "span", "br/", "h7"};
    string ent_words [0:8]  = '{"amp", "lt", "gt", "quot", "apos", "nbsp", "ampx", "Amp",
                                "copy"};

    html_to_text_byte_filter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (i_in_valid && !o_in_stall) sb.note_input(i_in_item);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_item);
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    task automatic send_byte(input bit [7:0] b, input bit ds);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_in_item.in_byte   <= b;
        i_in_item.doc_start <= ds;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_str(input string s, input bit mix_case);
        int       i;
        bit [7:0] c;
        for (i = 0; i < s.len(); i++) begin
            c = s[i];
            if (mix_case && c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'h20;
            send_byte(c, 1'b0);
        end
    endtask

    // hold input low until every expected byte has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_mode(input bit m);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.markup_mode = m;
    endtask

    task automatic send_entity();
        int       n;
        int       i;
        bit [7:0] c;
        send_byte("&", 1'b0);
        case ($urandom_range(0, 5))
            0, 1: send_str(ent_words[$urandom_range(0, 8)], 1'b0);
            2: send_str($sformatf("#%0d", $urandom_range(0, 400)), 1'b0);
            3: send_str($sformatf("#x%0h", $urandom_range(0, 400)), 1'b0);
            4: begin
                send_str($sformatf("#X%0h", $urandom_range(0, 99999)), 1'b0);
            end
            default: begin
                n = $urandom_range(0, 12);
                for (i = 0; i < n; i++) begin
                    c = $urandom_range(8'h20, 8'hFF);
                    if (c == "<" || c == ";") c = "z";
                    send_byte(c, 1'b0);
                end
            end
        endcase
        case ($urandom_range(0, 7))
            0: send_byte("<", 1'b0);
            1: send_byte("&", 1'b0);
            2: send_byte($urandom_range(0, 8'h1F), 1'b0);
            3: send_byte($urandom_range(0, 255), 1'b0);
            default: send_byte(";", 1'b0);
        endcase
    endtask

    task automatic send_tag();
        int i;
        int n;
        send_byte("<", 1'b0);
        if ($urandom_range(2) == 0) send_byte("/", 1'b0);
        if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, 18);
            for (i = 0; i < n; i++) send_byte($urandom_range("a", "z"), 1'b0);
        end else begin
            send_str(tag_words[$urandom_range(0, 15)], 1'b1);
        end
        if ($urandom_range(4) == 0) send_str(" id=\"9\"", 1'b0);
        if ($urandom_range(5) == 0) send_byte("/", 1'b0);
        send_byte(">", 1'b0);
    endtask

    task automatic send_script();
        string    name;
        int       i;
        int       n;
        bit [7:0] c;
        name = $urandom_range(1) ? "script" : "style";
        send_str({"<", name, ">"}, 1'b1);
        n = $urandom_range(2, 10);
        for (i = 0; i < n; i++) begin
            c = $urandom_range(8'h20, 8'h7E);
            if ($urandom_range(7) == 0) send_str("<b>", 1'b0);
            else if (c != "<") send_byte(c, 1'b0);
        end
        if ($urandom_range(4) == 0) send_str("</p>", 1'b0);
        send_str({"</", ($urandom_range(5) == 0) ? "style" : name, ">"}, 1'b1);
    endtask

    task automatic send_fragment();
        int       i;
        int       n;
        bit [7:0] c;
        case ($urandom_range(0, 11))
            0, 1: begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) begin
                    c = $urandom_range(8'h21, 8'h7E);
                    if (c == "<" || c == "&") c = "x";
                    send_byte(c, 1'b0);
                end
            end
            2: begin
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) begin
                    case ($urandom_range(0, 3))
                        0: send_byte(8'h20, 1'b0);
                        1: send_byte(8'h09, 1'b0);
                        2: send_byte(8'h0D, 1'b0);
                        default: send_byte(8'h0A, 1'b0);
                    endcase
                end
            end
            3, 4: send_tag();
            5, 6, 7: send_entity();
            8: send_script();
            9: send_byte($urandom_range(8'h80, 8'hFF), 1'b0);
            10: send_byte($urandom_range(0, 255), ($urandom_range(5) == 0));
            default: begin
                send_byte($urandom_range(1) ? "<" : "&", 1'b0);
                send_byte($urandom_range(0, 255), 1'b0);
            end
        endcase
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = sb.n_inputs + count;
        while (sb.n_inputs < stop_at) send_fragment();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_item     <= '0;
        send_idle_pct = 0;
        rcv_stall_pct = 0;
        idle_cycles   = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_mode(1'b1);

        send_idle_pct = 38;
        rcv_stall_pct = 86;
        send_byte(8'hFF, 1'b1);
        send_str(" \t\n<Br>&#x41;&q<p/>&nbsp;", 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        run_random(70);
        drain();

        send_idle_pct = 86;
        rcv_stall_pct = 38;
        write_mode(1'b0);
        run_random(40);
        drain();
        write_mode(1'b1);
        run_random(40);
        drain();

        send_idle_pct = 0;
        rcv_stall_pct = 0;
        send_byte("a", 1'b1);
        run_random(70);
        drain();

        $display("covered %0d input bytes in copy and filter modes, %0d output bytes checked",
                 sb.n_inputs, sb.n_results);
        $display("streams held text, whitespace, tags, entities, script/style and noise");
        if (sb.n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: html_to_text_byte_filter.f
+incdir+sv
sv/htt_pkg.sv
sv/htt_ctrl.sv
sv/htt_dp.sv
sv/html_to_text_byte_filter.sv
tb/tb_html_to_text_byte_filter.sv
